/* sv/cfae_pkg.sv */
// ----------------------------------------------------------------------------
// cfae_pkg: shared types and constants of the CAN frame ASCII encoder
// character codes, record layout, queue sizing and the hex digit function
// ----------------------------------------------------------------------------
package cfae_pkg;

   localparam int ID_W    = 11;
   localparam int LEN_W   = 4;
   localparam int DATA_W  = 64;
   localparam int STAMP_W = 16;
   localparam int CHAR_W  = 8;
   localparam int POS_W   = 5;

   localparam logic [CHAR_W-1:0] CHAR_START = 8'h74; // 't'
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D; // carriage return
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30; // '0'
   localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41; // 'A'
   localparam logic [3:0]        FIRST_LETTER = 4'd10;
   localparam logic [LEN_W-1:0]  MAX_BYTES    = 4'd8;

   // record positions: start char, three id digits, length digit
   localparam logic [POS_W-1:0] POS_START = 5'd0;
   localparam logic [POS_W-1:0] POS_ID2   = 5'd1;
   localparam logic [POS_W-1:0] POS_ID1   = 5'd2;
   localparam logic [POS_W-1:0] POS_ID0   = 5'd3;
   localparam logic [POS_W-1:0] POS_LEN   = 5'd4;
   localparam logic [POS_W-1:0] HEAD_CHARS   = 5'd5;
   localparam logic [POS_W-1:0] STAMP_DIGITS = 5'd4;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [ID_W-1:0]    frame_id;
      logic [LEN_W-1:0]   len;      // already saturated to eight
      logic [DATA_W-1:0]  payload;
      logic [STAMP_W-1:0] stamp;
   } rec_type;

   function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
      logic [CHAR_W-1:0] res;
      if (nib >= FIRST_LETTER) begin
         res = CHAR_A + {4'd0, nib - FIRST_LETTER};
      end else begin
         res = CHAR_ZERO + {4'd0, nib};
      end
      return res;
   endfunction

endpackage

/* sv/cfae_front.sv */
// ----------------------------------------------------------------------------
// cfae_front: frame intake and record queue
// keeps standard frames on an open channel, saturates length, queues them
// ----------------------------------------------------------------------------
module cfae_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  channel_open,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic                  in_extended,
   input  logic [cfae_pkg::ID_W-1:0]    in_frame_id,
   input  logic [cfae_pkg::LEN_W-1:0]   in_byte_count,
   input  logic [cfae_pkg::DATA_W-1:0]  in_payload,
   input  logic [cfae_pkg::STAMP_W-1:0] in_stamp,
   output logic                  q_valid,
   input  logic                  q_pop,
   output cfae_pkg::rec_type     q_rec
);

   cfae_pkg::rec_type                  queue_ff [cfae_pkg::QUEUE_DEPTH];
   logic [cfae_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [cfae_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [cfae_pkg::QCNT_W-1:0]        count_ff,  count_in;
   logic                               push;
   logic                               pop;
   cfae_pkg::rec_type                  new_rec;

   assign in_ready = (count_ff != cfae_pkg::QCNT_W'(cfae_pkg::QUEUE_DEPTH));
   assign push     = in_valid && in_ready && channel_open && !in_extended;
   assign q_valid  = (count_ff != '0);
   assign pop      = q_pop && q_valid;
   assign q_rec    = queue_ff[rd_ptr_ff];

   always_comb begin
      new_rec.frame_id = in_frame_id;
      new_rec.len      = (in_byte_count > cfae_pkg::MAX_BYTES) ? cfae_pkg::MAX_BYTES
                                                               : in_byte_count;
      new_rec.payload  = in_payload;
      new_rec.stamp    = in_stamp;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == cfae_pkg::QPTR_W'(cfae_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == cfae_pkg::QPTR_W'(cfae_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_rec;
      end
   end

endmodule

/* sv/cfae_back.sv */
// ----------------------------------------------------------------------------
// cfae_back: record sequencer
// walks one queued record a character per free cycle into the output register
// ----------------------------------------------------------------------------
module cfae_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_valid,
   output logic                         q_pop,
   input  cfae_pkg::rec_type            q_rec,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [cfae_pkg::CHAR_W-1:0]  out_char,
   output logic                         out_last
);

   cfae_pkg::rec_type                  rec_ff, rec_in;
   logic                               busy_ff, busy_in;
   logic [cfae_pkg::POS_W-1:0]         pos_ff, pos_in;
   logic                               valid_ff, valid_in;
   logic [cfae_pkg::CHAR_W-1:0]        char_ff, char_in;
   logic                               last_ff, last_in;

   logic                               out_free;
   logic                               emit;
   logic [cfae_pkg::CHAR_W-1:0]        cur_char;
   logic                               cur_last;
   logic [cfae_pkg::POS_W-1:0]         stamp_base;
   logic [cfae_pkg::POS_W-1:0]         data_off;
   logic [cfae_pkg::POS_W-1:0]         stamp_off;
   logic [3:0]                         data_nib_idx;
   logic [1:0]                         stamp_nib_idx;
   logic [11:0]                        id_wide;

   assign out_free   = !valid_ff || out_ready;
   assign emit       = busy_ff && out_free;
   assign stamp_base = cfae_pkg::HEAD_CHARS + {rec_ff.len, 1'b0};
   assign data_off   = pos_ff - cfae_pkg::HEAD_CHARS;
   assign stamp_off  = pos_ff - stamp_base;
   // byte k high nibble first: nibble index 2k+1 then 2k
   assign data_nib_idx  = {data_off[3:1], ~data_off[0]};
   assign stamp_nib_idx = ~stamp_off[1:0];
   assign id_wide       = {1'b0, rec_ff.frame_id};

   // character at the current position
   always_comb begin
      cur_last = 1'b0;
      case (pos_ff)
         cfae_pkg::POS_START: cur_char = cfae_pkg::CHAR_START;
         cfae_pkg::POS_ID2:   cur_char = cfae_pkg::hex_char(id_wide[11:8]);
         cfae_pkg::POS_ID1:   cur_char = cfae_pkg::hex_char(id_wide[7:4]);
         cfae_pkg::POS_ID0:   cur_char = cfae_pkg::hex_char(id_wide[3:0]);
         cfae_pkg::POS_LEN:   cur_char = cfae_pkg::hex_char(rec_ff.len);
         default: begin
            if (pos_ff < stamp_base) begin
               cur_char = cfae_pkg::hex_char(rec_ff.payload[data_nib_idx*4 +: 4]);
            end else if (pos_ff < stamp_base + cfae_pkg::STAMP_DIGITS) begin
               cur_char = cfae_pkg::hex_char(rec_ff.stamp[stamp_nib_idx*4 +: 4]);
            end else begin
               cur_char = cfae_pkg::CHAR_CR;
               cur_last = 1'b1;
            end
         end
      endcase
   end

   // take the next record when idle or on the closing character
   assign q_pop = q_valid && (!busy_ff || (emit && cur_last));

   always_comb begin
      rec_in   = rec_ff;
      busy_in  = busy_ff;
      pos_in   = pos_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      if (out_ready) begin
         valid_in = 1'b0;
      end
      if (emit) begin
         valid_in = 1'b1;
         char_in  = cur_char;
         last_in  = cur_last;
         pos_in   = pos_ff + 1'b1;
         if (cur_last) begin
            busy_in = 1'b0;
         end
      end
      if (q_pop) begin
         rec_in  = q_rec;
         busy_in = 1'b1;
         pos_in  = cfae_pkg::POS_START;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
         pos_ff   <= '0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff  <= rec_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign out_valid = valid_ff;
   assign out_char  = char_ff;
   assign out_last  = last_ff;

endmodule

/* sv/can_frame_to_ascii_encoder.sv */
// ----------------------------------------------------------------------------
// can_frame_to_ascii_encoder: CAN receive frame to serial-line ASCII record
// turns each standard frame into 't', id, length, data, timestamp and CR
// ----------------------------------------------------------------------------
// usage
//   req channel: one received frame per transfer; tuser is the extended-id
//     flag, tdata packs id, length code, eight data bytes and timestamp
//   rsp channel: one ASCII character per transfer, tlast on the closing CR
//   csr channel: one-bit channel open write, always ready; write it only
//     while no record is in flight
//   extended frames and frames on a closed channel are taken and dropped
//   a record is 10 to 26 characters; the sequencer emits one character per
//     cycle while the output register is free to take it
//   a frame passes through the queue, the back end's record register and the
//     output register before its first character appears
//   the back end loads the next record on the cycle of the closing CR, so
//     records leave back to back at one character per cycle unless stalled
//   a two-entry queue lets frames be taken while a record is still going out
//   receiver stall holds the output register and the sequencer; req_tready
//     drops only when the queue is full
//   reset empties the queue and output register and closes the channel
// ----------------------------------------------------------------------------
module can_frame_to_ascii_encoder (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data,     // channel_open
   // frame input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,    // frame_id[10:0], byte_count[14:11],
                                     // payload[78:15], stamp[94:79], pad
   input  logic        req_tuser,    // extended_id
   // character output
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,    // text_char
   output logic        rsp_tlast     // end_of_record
);

   logic              channel_open_ff, channel_open_in;
   logic              q_valid;
   logic              q_pop;
   cfae_pkg::rec_type q_rec;

   // configuration register, taken on every transfer
   assign csr_ready       = 1'b1;
   assign channel_open_in = (csr_valid && csr_ready) ? csr_data : channel_open_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_open_ff <= 1'b0;
      end else begin
         channel_open_ff <= channel_open_in;
      end
   end

   // front: classify and queue
   cfae_front u_front (
      .clock         (clock),
      .reset         (reset),
      .channel_open  (channel_open_ff),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .in_extended   (req_tuser),
      .in_frame_id   (req_tdata[10:0]),
      .in_byte_count (req_tdata[14:11]),
      .in_payload    (req_tdata[78:15]),
      .in_stamp      (req_tdata[94:79]),
      .q_valid       (q_valid),
      .q_pop         (q_pop),
      .q_rec         (q_rec)
   );

   // back: character sequencer and output register
   cfae_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_rec     (q_rec),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_char  (rsp_tdata),
      .out_last  (rsp_tlast)
   );

endmodule

/* sv/cfae_checker.sv */
// ----------------------------------------------------------------------------
// cfae_checker: port-level checks of the encoder
// output handshake, record framing and reset behavior
// ----------------------------------------------------------------------------
module cfae_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   logic rec_start_ff, rec_start_in;

   // next character transfer opens a record
   assign rec_start_in = (rsp_tvalid && rsp_tready) ? rsp_tlast : rec_start_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_start_ff <= 1'b1;
      end else begin
         rec_start_ff <= rec_start_in;
      end
   end

   a_hold_valid : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp valid dropped under stall");

   a_hold_data : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp payload changed under stall");

   a_last_is_cr : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata == cfae_pkg::CHAR_CR)
      else $error("record end is not a carriage return");

   a_start_char : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rec_start_ff |-> rsp_tdata == cfae_pkg::CHAR_START && !rsp_tlast)
      else $error("record does not open with start character");

   a_reset_idle : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("output valid right after reset");

endmodule

bind can_frame_to_ascii_encoder cfae_checker u_cfae_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

/* tb/sv/can_frame_to_ascii_encoder_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// can_frame_to_ascii_encoder_tb: self-checking bench for the CAN ASCII encoder
// clocked driver fed from a pending frame queue, each accepted frame expanded
// into its expected character record, clocked monitor checking every
// character transfer, channel opened and closed between phases, random
// stalls on both sides, one long receiver hold-off that fills the input queue
// ----------------------------------------------------------------------------
module can_frame_to_ascii_encoder_tb;

   // run limit in clock cycles, far above the slowest correct run
   localparam int CYCLE_LIMIT = 400000;
   // cycles allowed after the last character before a csr write or the end
   localparam int SETTLE_CYCLES = 8;
   // length of the long receiver hold-off
   localparam int LONG_HOLD_CYCLES = 300;

   // one received frame as the sender sees it
   typedef struct {
      bit        extended_id;
      bit [10:0] frame_id;
      bit [3:0]  byte_count;
      bit [63:0] payload;
      bit [15:0] stamp;
   } can_frame_type;

   // one character of an expected record
   typedef struct {
      logic [7:0] text_char;
      logic       end_of_record;
   } record_char_type;

   // dut ports, every input known from time zero
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic        csr_data   = 1'b0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata  = '0;    // frame_id[10:0], byte_count[14:11],
                                    // payload[78:15], stamp[94:79], pad
   logic        req_tuser  = 1'b0;  // extended_id
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;          // text_char
   logic        rsp_tlast;          // end_of_record

   // frames waiting to be offered, and characters still owed by the block
   can_frame_type   frame_pending_q[$];
   record_char_type record_char_q[$];

   can_frame_type   offer_frame;
   record_char_type want_char;

   // local copy of the channel_open register
   bit          chan_open_model = 1'b0;

   // idle percentages, set per phase by the stimulus process
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;

   // bookkeeping for idle detection
   int unsigned frames_queued   = 0;
   int unsigned frames_accepted = 0;
   int unsigned bad_count       = 0;
   int unsigned cycle_count     = 0;

   // long hold-off request: the stimulus flips the toggle, the receiver counts
   bit          hold_toggle = 1'b0;
   bit          hold_seen   = 1'b0;
   int unsigned hold_left   = 0;

   can_frame_to_ascii_encoder uut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // 20 ns clock period
   always #10 clock = ~clock;

   // ------------------------------------------------------------------------
   // expected record builder
   // ------------------------------------------------------------------------

   // uppercase hex digit of the low nibble
   function automatic logic [7:0] to_hex_ascii(input logic [3:0] nib);
      logic [7:0] ch;
      if (nib >= cfae_pkg::FIRST_LETTER) begin
         ch = cfae_pkg::CHAR_A + {4'd0, nib - cfae_pkg::FIRST_LETTER};
      end else begin
         ch = cfae_pkg::CHAR_ZERO + {4'd0, nib};
      end
      return ch;
   endfunction

   function automatic void push_char(input logic [7:0] ch, input logic last);
      record_char_type rc;
      rc.text_char     = ch;
      rc.end_of_record = last;
      record_char_q.push_back(rc);
   endfunction

   // appends the whole record for one accepted frame; a closed channel or an
   // extended id owes nothing
   function automatic void encode_record(input can_frame_type f);
      logic [3:0] n_bytes;
      logic [7:0] data_byte;
      if (!chan_open_model || f.extended_id) begin
         return;
      end
      // length codes above eight read as eight
      n_bytes = (f.byte_count > cfae_pkg::MAX_BYTES) ? cfae_pkg::MAX_BYTES : f.byte_count;
      push_char(cfae_pkg::CHAR_START, 1'b0);
      push_char(to_hex_ascii({1'b0, f.frame_id[10:8]}), 1'b0);
      push_char(to_hex_ascii(f.frame_id[7:4]), 1'b0);
      push_char(to_hex_ascii(f.frame_id[3:0]), 1'b0);
      push_char(to_hex_ascii(n_bytes), 1'b0);
      // byte 0 first, high nibble first; nothing at length zero
      for (int b = 0; b < n_bytes; b++) begin
         data_byte = f.payload[8*b +: 8];
         push_char(to_hex_ascii(data_byte[7:4]), 1'b0);
         push_char(to_hex_ascii(data_byte[3:0]), 1'b0);
      end
      push_char(to_hex_ascii(f.stamp[15:12]), 1'b0);
      push_char(to_hex_ascii(f.stamp[11:8]), 1'b0);
      push_char(to_hex_ascii(f.stamp[7:4]), 1'b0);
      push_char(to_hex_ascii(f.stamp[3:0]), 1'b0);
      push_char(cfae_pkg::CHAR_CR, 1'b1);
   endfunction

   // ------------------------------------------------------------------------
   // frame driver: offers pending frames, holds each until its transfer
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         // a transfer at this edge: book the record it owes
         if (req_tvalid && req_tready) begin
            encode_record(offer_frame);
            frames_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (frame_pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               offer_frame = frame_pending_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {1'b0, offer_frame.stamp, offer_frame.payload,
                              offer_frame.byte_count, offer_frame.frame_id};
               req_tuser  <= offer_frame.extended_id;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // character monitor: checks each transfer, then decides the next tready
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (record_char_q.size() == 0) begin
               $error("unexpected character transfer: text_char %h end_of_record %b",
                      rsp_tdata, rsp_tlast);
               bad_count++;
            end else begin
               want_char = record_char_q.pop_front();
               if (rsp_tdata !== want_char.text_char) begin
                  $error("text_char: expected %h, actual %h",
                         want_char.text_char, rsp_tdata);
                  bad_count++;
               end
               if (rsp_tlast !== want_char.end_of_record) begin
                  $error("end_of_record: expected %b, actual %b",
                         want_char.end_of_record, rsp_tlast);
                  bad_count++;
               end
            end
         end
         // a flipped toggle starts the long hold-off
         if (hold_seen != hold_toggle) begin
            hold_seen = hold_toggle;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("can_frame_to_ascii_encoder_tb NOT OK");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   task automatic add_frame(input bit ext, input bit [10:0] id, input bit [3:0] dlc,
                            input bit [63:0] data, input bit [15:0] ts);
      can_frame_type f;
      f.extended_id = ext;
      f.frame_id    = id;
      f.byte_count  = dlc;
      f.payload     = data;
      f.stamp       = ts;
      frame_pending_q.push_back(f);
      frames_queued++;
   endtask

   // random frames, mostly standard ids, all length codes
   task automatic add_random_frames(input int count);
      for (int i = 0; i < count; i++) begin
         add_frame($urandom_range(99) < 15, 11'($urandom_range(2047)),
                   4'($urandom_range(15)), {$urandom(), $urandom()},
                   16'($urandom_range(65535)));
      end
   endtask

   // every queued frame taken, every character arrived, then a short settle
   // so that a dropped frame still inside the block is gone as well
   task automatic wait_until_idle();
      while (frames_accepted != frames_queued || record_char_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // one csr transfer; the local register copy follows at the same edge
   task automatic write_channel_open(input bit open);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= open;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      chan_open_model = open;
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // channel closed out of reset: frames are taken and dropped
      send_idle_pct = 26;
      recv_idle_pct = 63;
      add_frame(1'b0, 11'h123, 4'd8, 64'h0123456789ABCDEF, 16'h1234);
      add_frame(1'b0, 11'h7FF, 4'd15, '1, 16'hFFFF);
      add_frame(1'b1, 11'h7FF, 4'd8, '1, 16'hFFFF);
      wait_until_idle();

      // directed frames on an open channel
      write_channel_open(1'b1);
      add_frame(1'b0, 11'h000, 4'd0, '0, 16'h0000);          // all zero, length zero
      add_frame(1'b0, 11'h7FF, 4'd8, '1, 16'hFFFF);          // all ones
      add_frame(1'b0, 11'h5A5, 4'd8, 64'hFEDCBA9876543210, 16'hA5C3);
      for (int n = 1; n < 8; n++) begin
         add_frame(1'b0, 11'(11'h2AA + n), 4'(n), 64'h0123456789ABCDEF,
                   16'(16'h5A3C + n));
      end
      add_frame(1'b0, 11'h19B, 4'd9, 64'h89ABCDEF01234567, 16'hBEEF);   // saturates
      add_frame(1'b0, 11'h64E, 4'd12, 64'h55AA33CC0FF0E11E, 16'h0F0F);  // saturates
      add_frame(1'b0, 11'h3C3, 4'd15, '1, 16'h00FF);                    // saturates
      add_frame(1'b1, 11'h123, 4'd8, 64'h0123456789ABCDEF, 16'h1234);   // extended, dropped
      add_frame(1'b1, 11'h000, 4'd0, '0, 16'h0000);                     // extended, dropped
      add_frame(1'b0, 11'h0F0, 4'd4, 64'hDEADBEEF0BADF00D, 16'hC0DE);
      add_frame(1'b0, 11'h70F, 4'd2, 64'h00000000000000FF, 16'hF000);
      wait_until_idle();

      // closed again: random frames must produce nothing
      write_channel_open(1'b0);
      add_random_frames(12);
      wait_until_idle();

      // open, random frames, sender idles less than the receiver
      write_channel_open(1'b1);
      add_random_frames(80);
      wait_until_idle();

      // the other way round
      send_idle_pct = 63;
      recv_idle_pct = 26;
      add_random_frames(80);
      wait_until_idle();

      // no idling; the long hold-off fills the block and stalls its input
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_toggle = ~hold_toggle;
      add_random_frames(80);
      wait_until_idle();

      if (record_char_q.size() != 0) begin
         $error("%0d expected characters never arrived", record_char_q.size());
      end
      if (bad_count == 0 && record_char_q.size() == 0) begin
         $display("can_frame_to_ascii_encoder_tb OK");
      end else begin
         $display("can_frame_to_ascii_encoder_tb NOT OK");
      end
      $finish;
   end

endmodule

/* filelist.f */
sv/cfae_pkg.sv
sv/cfae_front.sv
sv/cfae_back.sv
sv/can_frame_to_ascii_encoder.sv
sv/cfae_checker.sv
tb/sv/can_frame_to_ascii_encoder_tb.sv
